// ----- design/grid_astar_path_search_top_defines.svh -----
// Assertion macros for the grid path search block.
// Used by grid_astar_path_search_top; expects a signal named clock and one named reset.
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_DEFINES_SVH

// condition that must hold at every edge outside reset
`define GAPS_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition in one cycle implies a condition in the next
`define GAPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/gaps_pkg.sv -----
// Shared types, codes and step tables for the grid path search block.
// No dependencies.
`timescale 1ns / 1ps

package gaps_pkg;

   localparam int GRID_SIZE_DEF = 32;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] REG_WIDTH    = 2'd0;
   localparam logic [1:0] REG_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_DIAG     = 2'd2;
   localparam logic [1:0] REG_STRAIGHT = 2'd3;

   localparam logic [1:0] ST_UNVISITED = 2'd0;
   localparam logic [1:0] ST_OPEN      = 2'd1;
   localparam logic [1:0] ST_CLOSED    = 2'd2;

   localparam logic [13:0] G_MAX = 14'h3FFF;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] g;
      logic [2:0]  parent;
      logic [15:0] order;
   } node_type;

   // move order: four diagonals, then the four straight moves
   function automatic logic signed [1:0] step_dx(input logic [2:0] d);
      logic signed [1:0] r;
      unique case (d)
         3'd0, 3'd2, 3'd5: r = -2'sd1;
         3'd1, 3'd3, 3'd7: r = 2'sd1;
         default:          r = 2'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [1:0] step_dy(input logic [2:0] d);
      logic signed [1:0] r;
      unique case (d)
         3'd0, 3'd1, 3'd4: r = -2'sd1;
         3'd2, 3'd3, 3'd6: r = 2'sd1;
         default:          r = 2'sd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] manhattan(input logic [4:0] x, input logic [4:0] y,
                                            input logic [4:0] gx, input logic [4:0] gy);
      logic [4:0] a;
      logic [4:0] b;
      a = (x > gx) ? x - gx : gx - x;
      b = (y > gy) ? y - gy : gy - y;
      return {1'b0, a} + {1'b0, b};
   endfunction

endpackage

// ----- design/grid_astar_path_search_top.sv -----
// Grid path search block: occupancy grid load, 8-connected A* search, path readback.
// Depends on gaps_pkg, gaps_ram and grid_astar_path_search_top_defines.svh.
`timescale 1ns / 1ps
//
// Usage:
//  - req_* carries one command per transaction: write a grid cell, run a search from
//    (cell_x, cell_y) to (goal_x, goal_y), read one stored path point, or no operation.
//  - Every command returns exactly one rsp_* transaction with found, total_cost and
//    path_length of the last search, plus the point read (zero unless a read).
//  - csr_* writes the grid size and step costs; write them only while idle.
//  - After reset the occupancy memory is swept to free, with req_ready low. csr writes
//    are taken at any time.
//  - Cell write, no operation: the result is loaded in the finish state. Path read: a
//    read state first takes the registered path memory read data.
//  - Search: the node memory is cleared and the start placed, then per expansion one scan
//    of all w*h cells through the node memory read port, one close of the node and up to
//    8 moves, each checked against the occupancy and node memories; the path walk runs
//    twice, once to count the points and once to store them, then the goal is stored.
//  - One command is worked at a time. A new command is accepted while the previous
//    result still waits in the output register; a stalled receiver holds the next
//    result in the finish state until the output register frees.

`include "grid_astar_path_search_top_defines.svh"

module grid_astar_path_search_top
   import gaps_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic        req_blocked,
   input  logic [4:0]  req_goal_x,
   input  logic [4:0]  req_goal_y,
   input  logic [10:0] req_path_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [13:0] rsp_total_cost,
   output logic [10:0] rsp_path_length,
   output logic [4:0]  rsp_point_x,
   output logic [4:0]  rsp_point_y,
   output logic        rsp_bad_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int LIMIT = (GRID_SIZE < 32) ? GRID_SIZE : 32;
   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int LW    = $clog2(CELLS + 2);

   localparam logic [4:0] S_INIT    = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_READ    = 5'd2;
   localparam logic [4:0] S_FINISH  = 5'd3;
   localparam logic [4:0] S_NCLR    = 5'd4;
   localparam logic [4:0] S_START   = 5'd5;
   localparam logic [4:0] S_SCAN    = 5'd6;
   localparam logic [4:0] S_CLOSE   = 5'd7;
   localparam logic [4:0] S_NCALC   = 5'd8;
   localparam logic [4:0] S_NR1     = 5'd9;
   localparam logic [4:0] S_NR2     = 5'd10;
   localparam logic [4:0] S_NR3     = 5'd11;
   localparam logic [4:0] S_PW_CHK  = 5'd12;
   localparam logic [4:0] S_PW_STEP = 5'd13;
   localparam logic [4:0] S_PB_WR   = 5'd14;
   localparam logic [4:0] S_PB_STEP = 5'd15;
   localparam logic [4:0] S_PB_GOAL = 5'd16;

   function automatic logic [AW-1:0] cell_addr(input logic [4:0] x, input logic [4:0] y);
      return AW'(int'(y) * GRID_SIZE + int'(x));
   endfunction

   // control registers
   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [5:0]    width_ff, width_in, height_ff, height_in;
   logic [3:0]    diag_ff, diag_in, straight_ff, straight_in;
   logic          found_ff, found_in;
   logic [13:0]   cost_ff, cost_in;
   logic [LW-1:0] len_res_ff, len_res_in;
   logic [16:0]   ord_ff, ord_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          issue_ff, issue_in, pv_ff, pv_in, best_v_ff, best_v_in;

   // payload registers
   logic [4:0]    sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [4:0]    scan_x_ff, scan_x_in, scan_y_ff, scan_y_in, pvx_ff, pvx_in, pvy_ff, pvy_in;
   logic [4:0]    bx_ff, bx_in, by_ff, by_in;
   logic [14:0]   bf_ff, bf_in;
   logic [15:0]   bo_ff, bo_in;
   logic [13:0]   bg_ff, bg_in;
   logic [2:0]    bp_ff, bp_in, dir_ff, dir_in;
   logic [4:0]    nx_ff, nx_in, ny_ff, ny_in, wx_ff, wx_in, wy_ff, wy_in;
   logic          blk_ff, blk_in;
   logic [LW-1:0] wlen_ff, wlen_in, k_ff, k_in;
   logic [4:0]    px_ff, px_in, py_ff, py_in;
   logic          bad_ff, bad_in;
   logic          rsp_found_ff, rsp_found_in, rsp_bad_ff, rsp_bad_in;
   logic [13:0]   rsp_cost_ff, rsp_cost_in;
   logic [10:0]   rsp_len_ff, rsp_len_in;
   logic [4:0]    rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;

   // memory ports
   logic          occ_we, occ_wd, occ_rd;
   logic [AW-1:0] occ_wa, occ_ra;
   logic          node_we;
   logic [AW-1:0] node_wa, node_ra;
   node_type      node_wd, node_rd;
   logic [$bits(node_type)-1:0] node_rd_raw;
   logic          path_we;
   logic [LW-1:0] path_wa, path_ra;
   logic [9:0]    path_wd, path_rd;

   // datapath helpers
   logic [5:0]        w_eff, h_eff;
   logic signed [6:0] nxs, nys;
   logic [14:0]       f_scan, g_sum, nf, old_f;
   logic [13:0]       ng;
   logic [5:0]        dist_n;
   logic [2:0]        back_dir;
   logic              go_next, go_scan, req_fire;

   gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ_ram (
      .clock(clock), .wr_en(occ_we), .wr_addr(occ_wa), .wr_data(occ_wd),
      .rd_addr(occ_ra), .rd_data(occ_rd)
   );

   gaps_ram #(.WIDTH($bits(node_type)), .DEPTH(CELLS)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_rd_raw)
   );

   gaps_ram #(.WIDTH(10), .DEPTH(CELLS + 2)) u_path_ram (
      .clock(clock), .wr_en(path_we), .wr_addr(path_wa), .wr_data(path_wd),
      .rd_addr(path_ra), .rd_data(path_rd)
   );

   assign node_rd   = node_type'(node_rd_raw);
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign w_eff = (width_ff > 6'(LIMIT)) ? 6'(LIMIT) : width_ff;
   assign h_eff = (height_ff > 6'(LIMIT)) ? 6'(LIMIT) : height_ff;

   assign nxs    = $signed({2'b00, bx_ff}) + 7'(step_dx(dir_ff));
   assign nys    = $signed({2'b00, by_ff}) + 7'(step_dy(dir_ff));
   assign f_scan = {1'b0, node_rd.g} + 15'(manhattan(pvx_ff, pvy_ff, gx_ff, gy_ff));
   assign g_sum  = {1'b0, bg_ff} + 15'(dir_ff[2] ? straight_ff : diag_ff);
   assign ng     = (g_sum > {1'b0, G_MAX}) ? G_MAX : g_sum[13:0];
   assign dist_n = manhattan(nx_ff, ny_ff, gx_ff, gy_ff);
   assign nf     = {1'b0, ng} + 15'(dist_n);
   assign old_f  = {1'b0, node_rd.g} + 15'(dist_n);
   assign back_dir = node_rd.parent;

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;
      width_in = width_ff;  height_in = height_ff;
      diag_in = diag_ff;    straight_in = straight_ff;
      found_in = found_ff;  cost_in = cost_ff;  len_res_in = len_res_ff;  ord_in = ord_ff;
      issue_in = issue_ff;  pv_in = 1'b0;  best_v_in = best_v_ff;
      sx_in = sx_ff;  sy_in = sy_ff;  gx_in = gx_ff;  gy_in = gy_ff;
      scan_x_in = scan_x_ff;  scan_y_in = scan_y_ff;  pvx_in = pvx_ff;  pvy_in = pvy_ff;
      bx_in = bx_ff;  by_in = by_ff;  bf_in = bf_ff;  bo_in = bo_ff;  bg_in = bg_ff;
      bp_in = bp_ff;  dir_in = dir_ff;  nx_in = nx_ff;  ny_in = ny_ff;
      wx_in = wx_ff;  wy_in = wy_ff;  blk_in = blk_ff;  wlen_in = wlen_ff;  k_in = k_ff;
      px_in = px_ff;  py_in = py_ff;  bad_in = bad_ff;
      rsp_found_in = rsp_found_ff;  rsp_cost_in = rsp_cost_ff;  rsp_len_in = rsp_len_ff;
      rsp_px_in = rsp_px_ff;  rsp_py_in = rsp_py_ff;  rsp_bad_in = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      occ_we = 1'b0;  occ_wa = clr_ff;  occ_wd = 1'b0;  occ_ra = cell_addr(nx_ff, ny_ff);
      node_we = 1'b0;  node_wa = clr_ff;  node_wd = '0;  node_ra = cell_addr(wx_ff, wy_ff);
      path_we = 1'b0;  path_wa = k_ff - LW'(1);  path_wd = {wy_ff, wx_ff};
      path_ra = LW'(req_path_index);
      go_next = 1'b0;  go_scan = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WIDTH:    width_in = csr_wdata;
            REG_HEIGHT:   height_in = csr_wdata;
            REG_DIAG:     diag_in = csr_wdata[3:0];
            REG_STRAIGHT: straight_in = csr_wdata[3:0];
            default:      width_in = width_ff;
         endcase
      end

      unique case (state_ff)
         S_INIT: begin
            occ_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            px_in = '0;  py_in = '0;  bad_in = 1'b0;
            if (req_fire) begin
               unique case (req_opcode)
                  OP_WRITE: begin
                     if (int'(req_cell_x) < GRID_SIZE && int'(req_cell_y) < GRID_SIZE) begin
                        occ_we = 1'b1;
                        occ_wa = cell_addr(req_cell_x, req_cell_y);
                        occ_wd = req_blocked;
                     end
                     state_in = S_FINISH;
                  end
                  OP_SEARCH: begin
                     sx_in = req_cell_x;  sy_in = req_cell_y;
                     gx_in = req_goal_x;  gy_in = req_goal_y;
                     found_in = 1'b0;  cost_in = '0;  len_res_in = '0;  ord_in = '0;
                     clr_in = '0;
                     state_in = S_NCLR;
                  end
                  OP_READ: begin
                     bad_in = (int'(req_path_index) >= int'(len_res_ff)) ||
                              (int'(req_path_index) >= CELLS + 2);
                     state_in = S_READ;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_READ: begin
            if (!bad_ff) begin
               px_in = path_rd[4:0];
               py_in = path_rd[9:5];
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_cost_in  = cost_ff;
               rsp_len_in   = 11'(len_res_ff);
               rsp_px_in    = px_ff;
               rsp_py_in    = py_ff;
               rsp_bad_in   = bad_ff;
               state_in     = S_IDLE;
            end
         end
         S_NCLR: begin
            node_we = 1'b1;
            node_wd.status = ST_UNVISITED;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) state_in = S_START;
         end
         S_START: begin
            if ({1'b0, sx_ff} >= w_eff || {1'b0, sy_ff} >= h_eff) begin
               state_in = S_FINISH;
            end else begin
               node_we = 1'b1;
               node_wa = cell_addr(sx_ff, sy_ff);
               node_wd.status = ST_OPEN;
               ord_in = 17'd1;
               go_scan = 1'b1;
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               node_ra = cell_addr(scan_x_ff, scan_y_ff);
               pv_in = 1'b1;  pvx_in = scan_x_ff;  pvy_in = scan_y_ff;
               if ({1'b0, scan_x_ff} + 6'd1 == w_eff) begin
                  scan_x_in = '0;
                  if ({1'b0, scan_y_ff} + 6'd1 == h_eff) issue_in = 1'b0;
                  else scan_y_in = scan_y_ff + 5'd1;
               end else begin
                  scan_x_in = scan_x_ff + 5'd1;
               end
            end
            // ties keep the earliest insertion
            if (pv_ff && node_rd.status == ST_OPEN &&
                (!best_v_ff || f_scan < bf_ff || (f_scan == bf_ff && node_rd.order < bo_ff)))
            begin
               best_v_in = 1'b1;
               bx_in = pvx_ff;  by_in = pvy_ff;  bf_in = f_scan;
               bo_in = node_rd.order;  bg_in = node_rd.g;  bp_in = node_rd.parent;
            end
            if (!issue_ff && !pv_ff) state_in = best_v_ff ? S_CLOSE : S_FINISH;
         end
         S_CLOSE: begin
            node_we = 1'b1;
            node_wa = cell_addr(bx_ff, by_ff);
            node_wd = '{status: ST_CLOSED, g: bg_ff, parent: bp_ff, order: bo_ff};
            dir_in = '0;
            state_in = S_NCALC;
         end
         S_NCALC: begin
            if (nxs == $signed({2'b00, gx_ff}) && nys == $signed({2'b00, gy_ff})) begin
               // goal is taken when generated, ahead of bounds and obstacle checks
               wx_in = bx_ff;  wy_in = by_ff;  wlen_in = LW'(1);
               state_in = S_PW_CHK;
            end else if (nxs[6] || nys[6] || nxs >= $signed({1'b0, w_eff}) ||
                         nys >= $signed({1'b0, h_eff})) begin
               go_next = 1'b1;
            end else begin
               nx_in = nxs[4:0];  ny_in = nys[4:0];
               occ_ra = cell_addr(nxs[4:0], nys[4:0]);
               state_in = S_NR1;
            end
         end
         S_NR1: begin
            occ_ra = cell_addr(bx_ff, ny_ff);
            blk_in = occ_rd;
            state_in = S_NR2;
         end
         S_NR2: begin
            occ_ra = cell_addr(nx_ff, by_ff);
            blk_in = blk_ff | occ_rd;
            node_ra = cell_addr(nx_ff, ny_ff);
            state_in = S_NR3;
         end
         S_NR3: begin
            if (blk_ff || occ_rd) begin
               go_next = 1'b1;
            end else if (node_rd.status != ST_UNVISITED && old_f < nf) begin
               go_next = 1'b1;
            end else if (ord_ff[16]) begin
               // insertion order exhausted: search fails
               state_in = S_FINISH;
            end else begin
               node_we = 1'b1;
               node_wa = cell_addr(nx_ff, ny_ff);
               node_wd = '{status: ST_OPEN, g: ng, parent: dir_ff, order: ord_ff[15:0]};
               ord_in = ord_ff + 17'd1;
               go_next = 1'b1;
            end
         end
         S_PW_CHK: begin
            if ((wx_ff == sx_ff && wy_ff == sy_ff) || wlen_ff == LW'(CELLS)) begin
               k_in = wlen_ff;  wx_in = bx_ff;  wy_in = by_ff;
               state_in = S_PB_WR;
            end else begin
               state_in = S_PW_STEP;
            end
         end
         S_PW_STEP: begin
            wx_in = 5'({1'b0, wx_ff} - 6'(step_dx(back_dir)));
            wy_in = 5'({1'b0, wy_ff} - 6'(step_dy(back_dir)));
            wlen_in = wlen_ff + LW'(1);
            state_in = S_PW_CHK;
         end
         S_PB_WR: begin
            path_we = 1'b1;
            state_in = (k_ff == LW'(1)) ? S_PB_GOAL : S_PB_STEP;
         end
         S_PB_STEP: begin
            wx_in = 5'({1'b0, wx_ff} - 6'(step_dx(back_dir)));
            wy_in = 5'({1'b0, wy_ff} - 6'(step_dy(back_dir)));
            k_in = k_ff - LW'(1);
            state_in = S_PB_WR;
         end
         S_PB_GOAL: begin
            path_we = 1'b1;
            path_wa = wlen_ff;
            path_wd = {gy_ff, gx_ff};
            found_in = 1'b1;
            len_res_in = wlen_ff + LW'(1);
            cost_in = (bg_ff == G_MAX) ? G_MAX : bg_ff + 14'd1;
            state_in = S_FINISH;
         end
         default: state_in = S_IDLE;
      endcase

      if (go_next) begin
         if (dir_ff == 3'd7) begin
            go_scan = 1'b1;
         end else begin
            dir_in = dir_ff + 3'd1;
            state_in = S_NCALC;
         end
      end
      if (go_scan) begin
         scan_x_in = '0;  scan_y_in = '0;
         issue_in = 1'b1;  best_v_in = 1'b0;
         state_in = S_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;     clr_ff <= '0;
         width_ff <= 6'd20;      height_ff <= 6'd20;
         diag_ff <= 4'd7;        straight_ff <= 4'd5;
         found_ff <= 1'b0;       cost_ff <= '0;   len_res_ff <= '0;  ord_ff <= '0;
         rsp_valid_ff <= 1'b0;   issue_ff <= 1'b0; pv_ff <= 1'b0;   best_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;   clr_ff <= clr_in;
         width_ff <= width_in;   height_ff <= height_in;
         diag_ff <= diag_in;     straight_ff <= straight_in;
         found_ff <= found_in;   cost_ff <= cost_in;  len_res_ff <= len_res_in;
         ord_ff <= ord_in;
         rsp_valid_ff <= rsp_valid_in;  issue_ff <= issue_in;  pv_ff <= pv_in;
         best_v_ff <= best_v_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;  sy_ff <= sy_in;  gx_ff <= gx_in;  gy_ff <= gy_in;
      scan_x_ff <= scan_x_in;  scan_y_ff <= scan_y_in;  pvx_ff <= pvx_in;  pvy_ff <= pvy_in;
      bx_ff <= bx_in;  by_ff <= by_in;  bf_ff <= bf_in;  bo_ff <= bo_in;  bg_ff <= bg_in;
      bp_ff <= bp_in;  dir_ff <= dir_in;  nx_ff <= nx_in;  ny_ff <= ny_in;
      wx_ff <= wx_in;  wy_ff <= wy_in;  blk_ff <= blk_in;  wlen_ff <= wlen_in;  k_ff <= k_in;
      px_ff <= px_in;  py_ff <= py_in;  bad_ff <= bad_in;
      rsp_found_ff <= rsp_found_in;  rsp_cost_ff <= rsp_cost_in;  rsp_len_ff <= rsp_len_in;
      rsp_px_ff <= rsp_px_in;  rsp_py_ff <= rsp_py_in;  rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_total_cost  = rsp_cost_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_point_x     = rsp_px_ff;
   assign rsp_point_y     = rsp_py_ff;
   assign rsp_bad_index   = rsp_bad_ff;

   `GAPS_ASSERT_NEXT(a_rsp_only_from_finish, !rsp_valid_ff && state_ff != S_FINISH, !rsp_valid_ff, "response raised outside finish state")
   `GAPS_ASSERT_ALWAYS(a_order_bound, ord_ff <= 17'h10000, "insertion order overran its cap")
   `GAPS_ASSERT_ALWAYS(a_found_has_path, !found_ff || len_res_ff >= LW'(2), "found without a path")
   `GAPS_ASSERT_ALWAYS(a_path_index_range, state_ff != S_PB_WR || (k_ff >= LW'(1) && k_ff <= wlen_ff), "path write index out of range")

endmodule

// ----- design/gaps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gaps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
